@@ rtl/prs80_pkg.sv @@
// PRESENT-80 package: S-box, permutation layer and key schedule step.
// Used by the round stage, config registers and top level. No dependencies.
package prs80_pkg;

    localparam int PRS_ROUNDS    = 31;
    localparam int BLOCK_W       = 64;
    localparam int KEY_W         = 80;
    localparam int KEY_HI_W      = 16;
    localparam int RC_W          = 5;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;

    typedef logic [BLOCK_W-1:0]   t_block;
    typedef logic [KEY_W-1:0]     t_key;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [RC_W-1:0]      t_rc;

    localparam t_cfg_idx REG_KEY_LOW  = 2'd0;
    localparam t_cfg_idx REG_KEY_HIGH = 2'd1;

    localparam logic [3:0] SBOX [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };

    function automatic t_block sub_layer(input t_block s);
        t_block r;
        for (int n = 0; n < 16; n++) begin
            r[4*n +: 4] = SBOX[s[4*n +: 4]];
        end
        return r;
    endfunction

    function automatic t_block perm_layer(input t_block s);
        t_block r;
        for (int i = 0; i < BLOCK_W; i++) begin
            r[(i % 4) * 16 + (i / 4)] = s[i];
        end
        return r;
    endfunction

    function automatic t_block round_key(input t_key k);
        return k[KEY_W-1 -: BLOCK_W];
    endfunction

    function automatic t_key key_update(input t_key k, input t_rc rc);
        t_key n;
        n = {k[18:0], k[KEY_W-1:19]};
        n[79:76] = SBOX[n[79:76]];
        n[19:15] = n[19:15] ^ rc;
        return n;
    endfunction

endpackage

@@ rtl/prs80_cfg.sv @@
// PRESENT-80 key registers written through the config port.
// Depends on prs80_pkg.
module prs80_cfg
    import prs80_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_key                  o_key
);

    logic [63:0]         r_key_low;
    logic [KEY_HI_W-1:0] r_key_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_KEY_LOW) begin
                r_key_low <= i_cfg_data;
            end else if (i_cfg_index == REG_KEY_HIGH) begin
                r_key_high <= i_cfg_data[KEY_HI_W-1:0];
            end
        end
    end

    assign o_key = {r_key_high, r_key_low};

endmodule

@@ rtl/prs80_round.sv @@
// One PRESENT-80 round as a pipeline stage; key schedule travels with the data.
// Depends on prs80_pkg.
module prs80_round
    import prs80_pkg::*;
#(
    parameter t_rc RC = 5'd1
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_block i_state,
    input  t_key   i_key,
    output logic   o_valid,
    output t_block o_state,
    output t_key   o_key
);

    logic   r_valid;
    t_block r_state;
    t_key   r_key;
    t_block n_state;
    t_key   n_key;

    always_comb begin
        n_state = perm_layer(sub_layer(i_state ^ round_key(i_key)));
        n_key   = key_update(i_key, RC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
        r_key   <= n_key;
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;

endmodule

@@ rtl/present80_block_encrypt_core.sv @@
// PRESENT-80 encryption core: fully unrolled round pipeline plus output stage.
// Depends on prs80_pkg, prs80_cfg, prs80_round.
// An accepted start passes through each round register, then the output register, to o_valid.
// Throughput: one block per cycle; one register stage per round, final key XOR
// in the output register. o_busy is always low since results cannot be stalled.
// Reset (synchronous, active low) clears the keys and all stage valid bits.
module present80_block_encrypt_core
    import prs80_pkg::*;
#(
    parameter int ROUNDS = PRS_ROUNDS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [BLOCK_W-1:0]    i_plaintext,
    output logic                  o_valid,
    output logic [BLOCK_W-1:0]    o_ciphertext,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_key   w_cfg_key;
    logic   w_valid [ROUNDS+1];
    t_block w_state [ROUNDS+1];
    t_key   w_key   [ROUNDS+1];

    logic   r_valid;
    t_block r_ct;

    prs80_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_key       (w_cfg_key)
    );

    assign o_busy     = 1'b0;
    assign w_valid[0] = i_start && !o_busy;
    assign w_state[0] = i_plaintext;
    assign w_key[0]   = w_cfg_key;

    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        prs80_round #(
            .RC (t_rc'(g + 1))
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_state (w_state[g]),
            .i_key   (w_key[g]),
            .o_valid (w_valid[g+1]),
            .o_state (w_state[g+1]),
            .o_key   (w_key[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_valid[ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ct <= w_state[ROUNDS] ^ round_key(w_key[ROUNDS]);
    end

    assign o_valid      = r_valid;
    assign o_ciphertext = r_ct;

endmodule

@@ rtl/prs80_checker.sv @@
// Port-level checks for the PRESENT-80 core, bound to the top level.
// Depends on present80_block_encrypt_core ports only.
module prs80_checker #(
    parameter int ROUNDS = 31
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid
);

    localparam int LAT = ROUNDS + 1;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("core reported busy");

    a_start_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT o_valid)
        else $error("transaction result missing");

    a_result_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, LAT))
        else $error("result without matching transaction");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule

bind present80_block_encrypt_core prs80_checker #(
    .ROUNDS (ROUNDS)
) u_prs80_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_valid (o_valid)
);
